[rtl/ccct_pkg.sv]
// ----------------------------------------------------------------------------
// ccct_pkg: shared types and constants for the conflict cause counter table
// Request, result and queue types, cause classification, back end states.
// ----------------------------------------------------------------------------
`default_nettype none

package ccct_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int COUNT_BITS_DEF    = 32;
  localparam int MAX_RESULTS       = 16;
  localparam int QUEUE_DEPTH       = 2;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_DUMP = 1'b1;

  // structure kinds with their own classification rule
  localparam logic [2:0] KIND_RULE_PAIR  = 3'd0;
  localparam logic [2:0] KIND_RULE_SHARE = 3'd2;

  // operation codes named by the rule
  localparam logic [1:0] OP_CODE_0 = 2'd0;
  localparam logic [1:0] OP_CODE_1 = 2'd1;
  localparam logic [1:0] OP_CODE_2 = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [63:0] instance_tag;
    logic [2:0]  kind_id;
    logic [1:0]  op_code;
    logic [1:0]  conflict_op_code;
  } in_req_t;

  typedef struct packed {
    logic        entry_valid;
    logic [3:0]  entry_index;
    logic [63:0] out_tag;
    logic [2:0]  out_kind;
    logic [1:0]  out_op;
    logic [1:0]  out_conflict_op;
    logic        slow_path;
    logic [31:0] sample_count;
    logic        is_new;
    logic        table_full;
    logic        last;
  } out_rsp_t;

  // classified request as it waits in the queue
  typedef struct packed {
    in_req_t req;
    logic    slow;
  } q_entry_t;

  // table key: everything compared on a lookup
  typedef struct packed {
    logic [63:0] tag;
    logic [2:0]  kind;
    logic [1:0]  op;
    logic [1:0]  cop;
    logic        slow;
  } key_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  // slow path rule: class -1 when true, class 0 otherwise
  function automatic logic needs_slow(input logic [2:0] kind, input logic [1:0] op,
                                      input logic [1:0] cop);
    logic res;
    res = 1'b0;
    if (kind == KIND_RULE_PAIR) begin
      res = (op == OP_CODE_0 && cop == OP_CODE_1) || (op == OP_CODE_1 && cop == OP_CODE_0);
    end else if (kind == KIND_RULE_SHARE) begin
      res = !(op == OP_CODE_2 && cop == OP_CODE_2);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/ccct_front.sv]
// ----------------------------------------------------------------------------
// ccct_front: request intake and cause classification
// Takes a request while the queue has room and tags it with its slow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ccct_front (
  input  wire                   start,
  input  ccct_pkg::in_req_t     in_req,
  input  ccct_pkg::fifo_stat_t  q_stat,
  output logic                  busy,
  output logic                  q_push,
  output ccct_pkg::q_entry_t    q_data
);
  import ccct_pkg::*;

  assign busy   = q_stat.full;
  assign q_push = start && !q_stat.full;

  always_comb begin
    q_data.req  = in_req;
    // slow flag only matters for adds; harmless on a dump
    q_data.slow = needs_slow(in_req.kind_id, in_req.op_code, in_req.conflict_op_code);
  end

endmodule

`default_nettype wire

[rtl/ccct_queue.sv]
// ----------------------------------------------------------------------------
// ccct_queue: short request queue between front and back end
// Circular buffer of classified requests; push and pop in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccct_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  ccct_pkg::q_entry_t    push_data,
  input  wire                   pop,
  output ccct_pkg::q_entry_t    pop_data,
  output ccct_pkg::fifo_stat_t  stat
);
  import ccct_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (level_r == LVL_W'(QUEUE_DEPTH));
  assign stat.empty = (level_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/ccct_back.sv]
// ----------------------------------------------------------------------------
// ccct_back: table engine
// Linear lookup and update for adds, selection by repeated scans for dumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ccct_back #(
  parameter int TABLE_ENTRIES = ccct_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = ccct_pkg::COUNT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  ccct_pkg::q_entry_t    q_data,
  input  ccct_pkg::fifo_stat_t  q_stat,
  output logic                  q_pop,
  output logic                  out_strobe,
  output ccct_pkg::out_rsp_t    out_rsp
);
  import ccct_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  // entry memories, one read and one write port
  key_t                  key_mem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];

  back_state_t           state_r, state_nxt;
  q_entry_t              req_r, req_nxt;
  logic [CNT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r;
  key_t                  key_rd_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [TABLE_ENTRIES-1:0] done_r, done_nxt;
  logic                  best_found_r, best_found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  key_t                  best_key_r, best_key_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;
  logic [RES_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic [RES_W-1:0]      limit_r, limit_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_rsp_t              out_rsp_r, out_rsp_nxt;

  logic                  issue;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  key_t                  wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;
  key_t                  req_key, q_key;
  logic                  hit, last_cmp, cand, last_res;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           total_ext;

  assign req_key  = '{tag: req_r.req.instance_tag, kind: req_r.req.kind_id,
                      op: req_r.req.op_code, cop: req_r.req.conflict_op_code,
                      slow: req_r.slow};
  assign q_key    = '{tag: q_data.req.instance_tag, kind: q_data.req.kind_id,
                      op: q_data.req.op_code, cop: q_data.req.conflict_op_code,
                      slow: q_data.slow};
  assign issue    = (state_r == BK_SCAN) && (scan_idx_r < total_r);
  assign rd_addr  = scan_idx_r[IDX_W-1:0];
  assign hit      = rd_vld_r && (key_rd_r == req_key);
  assign last_cmp = rd_vld_r && ((CNT_W'(rd_idx_r) + CNT_W'(1)) == total_r);
  assign cnt_inc  = (&cnt_rd_r) ? cnt_rd_r : cnt_rd_r + COUNT_BITS'(1);
  assign cand     = rd_vld_r && !done_r[rd_idx_r] &&
                    (!best_found_r || (cnt_rd_r > best_cnt_r));
  assign last_res = ((out_cnt_r + RES_W'(1)) == limit_r);
  assign total_ext = 32'(total_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && total_r != '0) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (req_r.req.cmd == CMD_ADD) begin
          if (hit || last_cmp) begin
            state_nxt = BK_IDLE;
          end
        end else if (last_cmp && last_res) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    q_pop          = 1'b0;
    req_nxt        = req_r;
    scan_idx_nxt   = scan_idx_r;
    total_nxt      = total_r;
    rd_vld_nxt     = issue;
    done_nxt       = done_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_cnt_nxt   = best_cnt_r;
    out_cnt_nxt    = out_cnt_r;
    limit_nxt      = limit_r;
    wr_en          = 1'b0;
    wr_idx         = rd_idx_r;
    wr_key         = req_key;
    wr_cnt         = cnt_inc;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = '0;

    if (issue) begin
      scan_idx_nxt = scan_idx_r + CNT_W'(1);
    end

    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop          = 1'b1;
          req_nxt        = q_data;
          scan_idx_nxt   = '0;
          out_cnt_nxt    = '0;
          best_found_nxt = 1'b0;
          done_nxt       = '0;
          limit_nxt      = (total_ext > 32'(MAX_RESULTS)) ? RES_W'(MAX_RESULTS)
                                                          : RES_W'(total_ext);
          if (total_r == '0) begin
            out_strobe_nxt   = 1'b1;
            out_rsp_nxt.last = 1'b1;
            if (q_data.req.cmd == CMD_ADD) begin
              // empty table: first entry goes straight in
              wr_en   = 1'b1;
              wr_idx  = '0;
              wr_key  = q_key;
              wr_cnt  = COUNT_BITS'(1);
              total_nxt = CNT_W'(1);
              out_rsp_nxt.entry_valid     = 1'b1;
              out_rsp_nxt.out_tag         = q_key.tag;
              out_rsp_nxt.out_kind        = q_key.kind;
              out_rsp_nxt.out_op          = q_key.op;
              out_rsp_nxt.out_conflict_op = q_key.cop;
              out_rsp_nxt.slow_path       = q_key.slow;
              out_rsp_nxt.sample_count    = 32'(1);
              out_rsp_nxt.is_new          = 1'b1;
            end
          end
        end
      end
      BK_SCAN: begin
        if (req_r.req.cmd == CMD_ADD) begin
          out_rsp_nxt.out_tag         = req_key.tag;
          out_rsp_nxt.out_kind        = req_key.kind;
          out_rsp_nxt.out_op          = req_key.op;
          out_rsp_nxt.out_conflict_op = req_key.cop;
          out_rsp_nxt.slow_path       = req_key.slow;
          out_rsp_nxt.last            = 1'b1;
          if (hit) begin
            wr_en          = 1'b1;
            out_strobe_nxt = 1'b1;
            out_rsp_nxt.entry_valid  = 1'b1;
            out_rsp_nxt.entry_index  = 4'(rd_idx_r);
            out_rsp_nxt.sample_count = 32'(cnt_inc);
          end else if (last_cmp) begin
            out_strobe_nxt = 1'b1;
            if (total_r == CNT_W'(TABLE_ENTRIES)) begin
              out_rsp_nxt.table_full = 1'b1;
            end else begin
              wr_en     = 1'b1;
              wr_idx    = total_r[IDX_W-1:0];
              wr_cnt    = COUNT_BITS'(1);
              total_nxt = total_r + CNT_W'(1);
              out_rsp_nxt.entry_valid  = 1'b1;
              out_rsp_nxt.entry_index  = 4'(total_r[IDX_W-1:0]);
              out_rsp_nxt.sample_count = 32'(1);
              out_rsp_nxt.is_new       = 1'b1;
            end
          end
        end else begin
          // strict compare in ascending order keeps ties in table order
          if (cand) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = rd_idx_r;
            best_key_nxt   = key_rd_r;
            best_cnt_nxt   = cnt_rd_r;
          end
          if (last_cmp) begin
            out_strobe_nxt = 1'b1;
            out_rsp_nxt.entry_valid     = 1'b1;
            out_rsp_nxt.entry_index     = 4'(best_idx_nxt);
            out_rsp_nxt.out_tag         = best_key_nxt.tag;
            out_rsp_nxt.out_kind        = best_key_nxt.kind;
            out_rsp_nxt.out_op          = best_key_nxt.op;
            out_rsp_nxt.out_conflict_op = best_key_nxt.cop;
            out_rsp_nxt.slow_path       = best_key_nxt.slow;
            out_rsp_nxt.sample_count    = 32'(best_cnt_nxt);
            out_rsp_nxt.last            = last_res;
            done_nxt[best_idx_nxt]      = 1'b1;
            out_cnt_nxt                 = out_cnt_r + RES_W'(1);
            best_found_nxt              = 1'b0;
            scan_idx_nxt                = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      total_r      <= '0;
      rd_vld_r     <= 1'b0;
      done_r       <= '0;
      best_found_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      rd_vld_r     <= rd_vld_nxt;
      done_r       <= done_nxt;
      best_found_r <= best_found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_addr;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    best_cnt_r <= best_cnt_nxt;
    out_cnt_r  <= out_cnt_nxt;
    limit_r    <= limit_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_key;
      cnt_mem[wr_idx] <= wr_cnt;
    end
    key_rd_r <= key_mem[rd_addr];
    cnt_rd_r <= cnt_mem[rd_addr];
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

`default_nettype wire

[rtl/conflict_cause_counter_table_core.sv]
// ----------------------------------------------------------------------------
// conflict_cause_counter_table_core: abort cause counter table
// Counts classified abort samples per key and dumps them by descending count.
// ----------------------------------------------------------------------------
//
// Channel   Ports                     Direction  Handshake
// request   start, busy, in_req       in         taken when start && !busy
// result    out_strobe, out_rsp       out        one-cycle strobe per result, no stall
//
// An add is one scan that stops at a hit or at the last entry; the result is
// registered. Each dump result is one full scan of the table. On an empty
// table an add or a dump is answered straight from idle without a scan.
// The single read port of the entry memory looks at one entry per cycle.
// A two-deep queue sits between intake and the table engine; busy is high
// only while it is full. Reset clears the entry count and control state; no
// clearing pass is needed, entries at or above the entry count are never read.
//
`default_nettype none

module conflict_cause_counter_table_core #(
  parameter int TABLE_ENTRIES = ccct_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = ccct_pkg::COUNT_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  ccct_pkg::in_req_t   in_req,
  output logic                out_strobe,
  output ccct_pkg::out_rsp_t  out_rsp
);
  import ccct_pkg::*;

  fifo_stat_t q_stat;
  q_entry_t   q_push_data;
  q_entry_t   q_pop_data;
  logic       q_push;
  logic       q_pop;

  // intake: classify and enqueue
  ccct_front u_front (
    .start  (start),
    .in_req (in_req),
    .q_stat (q_stat),
    .busy   (busy),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  // decouples intake from the table engine
  ccct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  // table engine: lookup/update on add, ranked readout on dump
  ccct_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_pop_data),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

endmodule

`default_nettype wire

[bench/conflict_cause_counter_table_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conflict_cause_counter_table_core_tb: self-checking bench for the cause table
// Directed rows, then random add/dump traffic, checked against a local table
// model with saturating counts, full-table drops and count-ordered dumps.
// ----------------------------------------------------------------------------

module conflict_cause_counter_table_core_tb;
  import ccct_pkg::*;

  localparam int TBL_DEPTH    = TABLE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 240;
  localparam int DRAIN_CYCLES = 300;  // covers a full 16-entry dump

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_strobe;
  out_rsp_t out_rsp;

  conflict_cause_counter_table_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Timeout: well above the slowest legal run (every item a full dump).
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Local copy of the cause table. Entries at or above cause_used are never
  // looked at, mirroring the block.
  // --------------------------------------------------------------------------
  logic [63:0] cause_tag  [TBL_DEPTH];
  logic [2:0]  cause_kind [TBL_DEPTH];
  logic [1:0]  cause_op   [TBL_DEPTH];
  logic [1:0]  cause_cop  [TBL_DEPTH];
  logic        cause_slow [TBL_DEPTH];
  logic [31:0] cause_cnt  [TBL_DEPTH];
  int          cause_used = 0;

  out_rsp_t step_rsp[$];     // results of the request just taken
  out_rsp_t pending_rsp[$];  // results still owed by the block, oldest first

  int mismatch_count = 0;
  int n_add = 0, n_dump = 0, n_checked = 0, n_new = 0, n_dropped = 0;
  int gap_pct = 12;

  // Slow path rule: kind 0 only for the crossed 0/1 pair, kind 2 for all
  // pairs but 2/2, every other kind never.
  function automatic logic slow_cause(input logic [2:0] kind, input logic [1:0] op,
                                      input logic [1:0] cop);
    logic res;
    res = 1'b0;
    case (kind)
      KIND_RULE_PAIR:  res = ({op, cop} == {OP_CODE_0, OP_CODE_1}) ||
                             ({op, cop} == {OP_CODE_1, OP_CODE_0});
      KIND_RULE_SHARE: res = ({op, cop} != {OP_CODE_2, OP_CODE_2});
      default:         res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic out_rsp_t make_rsp(input logic valid, input logic [3:0] idx,
                                        input logic [63:0] tag, input logic [2:0] kind,
                                        input logic [1:0] op, input logic [1:0] cop,
                                        input logic slow, input logic [31:0] cnt,
                                        input logic is_new, input logic full,
                                        input logic last);
    out_rsp_t r;
    r.entry_valid     = valid;
    r.entry_index     = idx;
    r.out_tag         = tag;
    r.out_kind        = kind;
    r.out_op          = op;
    r.out_conflict_op = cop;
    r.slow_path       = slow;
    r.sample_count    = cnt;
    r.is_new          = is_new;
    r.table_full      = full;
    r.last            = last;
    return r;
  endfunction

  function automatic in_req_t add_req(input logic [63:0] tag, input logic [2:0] kind,
                                      input logic [1:0] op, input logic [1:0] cop);
    in_req_t r;
    r.cmd              = CMD_ADD;
    r.instance_tag     = tag;
    r.kind_id          = kind;
    r.op_code          = op;
    r.conflict_op_code = cop;
    return r;
  endfunction

  // Update the local table for one request and leave its results in step_rsp.
  task automatic count_cause(input in_req_t r);
    logic slow;
    int   hit;
    int   rank;
    int   nres;
    int   e;
    int   order[TBL_DEPTH];
    step_rsp.delete();
    if (r.cmd == CMD_ADD) begin
      slow = slow_cause(r.kind_id, r.op_code, r.conflict_op_code);
      hit  = -1;
      for (int i = 0; i < cause_used; i++) begin
        if (hit < 0 && cause_tag[i] == r.instance_tag && cause_kind[i] == r.kind_id &&
            cause_op[i] == r.op_code && cause_cop[i] == r.conflict_op_code &&
            cause_slow[i] == slow)
          hit = i;
      end
      if (hit >= 0) begin
        if (cause_cnt[hit] != '1) cause_cnt[hit] = cause_cnt[hit] + 1;  // saturate
        step_rsp.push_back(make_rsp(1'b1, hit[3:0], r.instance_tag, r.kind_id, r.op_code,
                                    r.conflict_op_code, slow, cause_cnt[hit],
                                    1'b0, 1'b0, 1'b1));
      end else if (cause_used >= TBL_DEPTH) begin
        // table full: sample dropped, key echoed back
        step_rsp.push_back(make_rsp(1'b0, 4'd0, r.instance_tag, r.kind_id, r.op_code,
                                    r.conflict_op_code, slow, 32'd0,
                                    1'b0, 1'b1, 1'b1));
      end else begin
        e = cause_used;
        cause_tag[e]  = r.instance_tag;
        cause_kind[e] = r.kind_id;
        cause_op[e]   = r.op_code;
        cause_cop[e]  = r.conflict_op_code;
        cause_slow[e] = slow;
        cause_cnt[e]  = 32'd1;
        cause_used++;
        step_rsp.push_back(make_rsp(1'b1, e[3:0], r.instance_tag, r.kind_id, r.op_code,
                                    r.conflict_op_code, slow, 32'd1,
                                    1'b1, 1'b0, 1'b1));
      end
    end else if (cause_used == 0) begin
      step_rsp.push_back(make_rsp(1'b0, 4'd0, 64'd0, 3'd0, 2'd0, 2'd0, 1'b0, 32'd0,
                                  1'b0, 1'b0, 1'b1));
    end else begin
      // rank = entries with a higher count, plus earlier entries with an equal one
      for (int i = 0; i < cause_used; i++) begin
        rank = 0;
        for (int j = 0; j < cause_used; j++) begin
          if (cause_cnt[j] > cause_cnt[i] || (cause_cnt[j] == cause_cnt[i] && j < i))
            rank++;
        end
        order[rank] = i;
      end
      nres = (cause_used < MAX_RESULTS) ? cause_used : MAX_RESULTS;
      for (int k = 0; k < nres; k++) begin
        e = order[k];
        step_rsp.push_back(make_rsp(1'b1, e[3:0], cause_tag[e], cause_kind[e], cause_op[e],
                                    cause_cop[e], cause_slow[e], cause_cnt[e],
                                    1'b0, 1'b0, k == nres - 1));
      end
    end
  endtask

  // Present one request, with random idle cycles ahead of it, and hold it
  // until the block takes it. busy is sampled at the edge, before the block's
  // own updates land, so it is the value the block saw.
  task automatic issue(input in_req_t r, input logic typed, input out_rsp_t typed_rsp);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    // request taken at this edge
    count_cause(r);
    if (r.cmd == CMD_ADD) n_add++;
    else n_dump++;
    if (typed) pending_rsp.push_back(typed_rsp);
    else foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    out_rsp_t exp;
    string    bad;
    if (rst_n && out_strobe) begin
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h with nothing owed", out_rsp);
      end else begin
        exp = pending_rsp.pop_front();
        n_checked++;
        if (exp.is_new) n_new++;
        if (exp.table_full) n_dropped++;
        bad = "";
        if (out_rsp.entry_valid !== exp.entry_valid)         bad = {bad, " entry_valid"};
        if (out_rsp.entry_index !== exp.entry_index)         bad = {bad, " entry_index"};
        if (out_rsp.out_tag !== exp.out_tag)                 bad = {bad, " out_tag"};
        if (out_rsp.out_kind !== exp.out_kind)               bad = {bad, " out_kind"};
        if (out_rsp.out_op !== exp.out_op)                   bad = {bad, " out_op"};
        if (out_rsp.out_conflict_op !== exp.out_conflict_op) bad = {bad, " out_conflict_op"};
        if (out_rsp.slow_path !== exp.slow_path)             bad = {bad, " slow_path"};
        if (out_rsp.sample_count !== exp.sample_count)       bad = {bad, " sample_count"};
        if (out_rsp.is_new !== exp.is_new)                   bad = {bad, " is_new"};
        if (out_rsp.table_full !== exp.table_full)           bad = {bad, " table_full"};
        if (out_rsp.last !== exp.last)                       bad = {bad, " last"};
        if (bad != "") begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d differs in%s: expected %h, got %h",
                     n_checked, bad, exp, out_rsp);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  in_req_t  dir_req[$];
  logic     dir_typed[$];
  out_rsp_t dir_exp[$];

  task automatic row(input in_req_t r, input logic typed, input out_rsp_t e);
    dir_req.push_back(r);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endtask

  initial begin : stim
    in_req_t  r;
    in_req_t  dump_req;
    int       pick;
    int       idx;
    logic [63:0] tag_a, tag_b;

    dump_req      = '0;
    dump_req.cmd  = CMD_DUMP;
    tag_a = 64'hDEAD_BEEF_0BAD_F00D;
    tag_b = 64'h7FFF_0000_FFFF_8001;

    // Directed rows. Typed expectations only where obvious; the rest come
    // from the local table.
    row(dump_req, 1'b1, make_rsp(1'b0, 4'd0, 64'd0, 3'd0, 2'd0, 2'd0, 1'b0, 32'd0,
                                 1'b0, 1'b0, 1'b1));                       // empty dump
    row(add_req(64'd0, KIND_RULE_PAIR, OP_CODE_0, OP_CODE_1), 1'b1,
        make_rsp(1'b1, 4'd0, 64'd0, KIND_RULE_PAIR, OP_CODE_0, OP_CODE_1, 1'b1, 32'd1,
                 1'b1, 1'b0, 1'b1));                                       // first entry
    row(add_req('1, 3'd7, 2'd3, 2'd3), 1'b1,
        make_rsp(1'b1, 4'd1, '1, 3'd7, 2'd3, 2'd3, 1'b0, 32'd1,
                 1'b1, 1'b0, 1'b1));                                       // all-ones key
    row(add_req(64'd1, KIND_RULE_PAIR, OP_CODE_1, OP_CODE_0), 1'b0, '0);
    row(add_req(64'd1, KIND_RULE_PAIR, OP_CODE_2, OP_CODE_2), 1'b0, '0);
    row(add_req(64'h5555_5555_5555_5555, KIND_RULE_PAIR, OP_CODE_0, OP_CODE_0), 1'b0, '0);
    row(add_req(64'hAAAA_AAAA_AAAA_AAAA, KIND_RULE_SHARE, OP_CODE_2, OP_CODE_2), 1'b0, '0);
    row(add_req(64'h0123_4567_89AB_CDEF, KIND_RULE_SHARE, OP_CODE_0, OP_CODE_1), 1'b0, '0);
    row(add_req(64'h0123_4567_89AB_CDEF, KIND_RULE_SHARE, 2'd3, 2'd3), 1'b0, '0);
    row(add_req(64'hFEDC_BA98_7654_3210, 3'd1, OP_CODE_0, OP_CODE_1), 1'b0, '0);
    row(add_req(64'd0, KIND_RULE_PAIR, OP_CODE_0, OP_CODE_1), 1'b0, '0);   // hit
    row(dump_req, 1'b0, '0);
    row(add_req(64'h0000_0001_0000_0000, 3'd3, OP_CODE_1, OP_CODE_2), 1'b0, '0);
    row(add_req(64'h8000_0000_0000_0000, 3'd4, OP_CODE_2, OP_CODE_1), 1'b0, '0);
    row(add_req(64'h0F0F_0F0F_F0F0_F0F0, 3'd5, OP_CODE_0, OP_CODE_1), 1'b0, '0);
    row(add_req(64'hF0F0_F0F0_0F0F_0F0F, 3'd6, OP_CODE_1, OP_CODE_0), 1'b0, '0);
    row(add_req(64'h8000_0000_0000_0000, 3'd7, OP_CODE_0, OP_CODE_0), 1'b0, '0);
    row(add_req(64'h0000_FFFF_0000_FFFF, 3'd1, 2'd3, OP_CODE_2), 1'b0, '0);
    row(add_req(64'hFFFF_0000_FFFF_0000, KIND_RULE_SHARE, OP_CODE_2, OP_CODE_0),
        1'b0, '0);                                                         // sixteenth
    // table now full: new keys are dropped with their key echoed
    row(add_req(tag_a, 3'd4, OP_CODE_1, OP_CODE_1), 1'b1,
        make_rsp(1'b0, 4'd0, tag_a, 3'd4, OP_CODE_1, OP_CODE_1, 1'b0, 32'd0,
                 1'b0, 1'b1, 1'b1));
    row(add_req(tag_b, KIND_RULE_PAIR, OP_CODE_1, OP_CODE_0), 1'b1,
        make_rsp(1'b0, 4'd0, tag_b, KIND_RULE_PAIR, OP_CODE_1, OP_CODE_0, 1'b1, 32'd0,
                 1'b0, 1'b1, 1'b1));
    row(add_req('1, 3'd7, 2'd3, 2'd3), 1'b0, '0);                          // hit when full
    row(dump_req, 1'b0, '0);                                               // 16 results

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_req[i]) issue(dir_req[i], dir_typed[i], dir_exp[i]);

    // Random part: mostly hits on live keys so counts spread out and dumps
    // reorder, some fresh keys that hit the full table, some dumps.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      gap_pct = (k >= 80 && k < 150) ? 0 : 12;  // one long stretch without gaps
      pick = $urandom_range(0, 99);
      r    = '0;
      if (pick < 10) begin
        r.cmd              = CMD_DUMP;
        r.instance_tag     = {$urandom, $urandom};  // ignored on dump
        r.kind_id          = 3'($urandom_range(0, 7));
        r.op_code          = 2'($urandom_range(0, 3));
        r.conflict_op_code = 2'($urandom_range(0, 3));
      end else if (pick < 80 && cause_used > 0) begin
        idx = $urandom_range(0, cause_used - 1);
        r   = add_req(cause_tag[idx], cause_kind[idx], cause_op[idx], cause_cop[idx]);
      end else begin
        r = add_req({$urandom, $urandom}, 3'($urandom_range(0, 7)),
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
      issue(r, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);  // catch any stray result

    $display("Covered %0d adds and %0d dumps; %0d results checked", n_add, n_dump,
             n_checked);
    $display("%0d entries created, %0d samples dropped on a full table", n_new, n_dropped);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
